// ===== rtl/ksrt_pkg.sv =====
// Shared types and constants for the keyed stock record table.
// Holds the request and status codes and the layout of one stored slot.
// No dependencies.
package ksrt_pkg;

	localparam int KEY_W  = 40;
	localparam int RATE_W = 24;
	localparam int QTY_W  = 32;
	localparam int REQ_W  = 3;
	localparam int STAT_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT  = 3'd0,
		REQ_DELETE  = 3'd1,
		REQ_LOOKUP  = 3'd2,
		REQ_SET_ADD = 3'd3,
		REQ_SUB     = 3'd4
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EXISTS    = 2'd3
	} status_t;

	typedef struct packed {
		logic                    valid;
		logic [KEY_W-1:0]        key;
		logic [RATE_W-1:0]       rate;
		logic signed [QTY_W-1:0] qty;
	} slot_t;

endpackage

// ===== rtl/ksrt_bucket.sv =====
// Bucket index unit: key modulo BUCKETS, one key byte at a time by reciprocal
// multiplication and a remainder step; a power-of-two bucket count takes the low key bits.
// Depends on ksrt_pkg.
module ksrt_bucket
	import ksrt_pkg::*;
#(
	parameter int BUCKETS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [KEY_W-1:0]           key,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] bucket
);

	localparam int BW     = $clog2(BUCKETS);
	localparam int XW     = BW + 8;
	localparam int MW     = 28;
	localparam int SH     = 28;
	localparam int PW     = XW + MW;
	localparam int NCHUNK = KEY_W / 8;
	localparam int CW     = $clog2(NCHUNK);
	localparam bit POW2   = (BUCKETS & (BUCKETS - 1)) == 0;
	localparam logic [XW-1:0] DIVISOR    = XW'(BUCKETS);
	localparam logic [MW-1:0] RECIP      = MW'(((1 << SH) + BUCKETS - 1) / BUCKETS);
	localparam logic [CW-1:0] LAST_CHUNK = CW'(NCHUNK - 1);

	logic [BW-1:0]    rem_q;
	logic [KEY_W-1:0] sh_q;
	logic [XW-1:0]    x_q;
	logic [7:0]       quo_q;
	logic [CW-1:0]    cnt_q;
	logic             phase_q;
	logic             busy_q;
	logic             done_q;
	logic [XW-1:0]    x_cat;
	logic [PW-1:0]    prod;
	logic [XW-1:0]    rem_full;

	// The running remainder times 256 plus the next byte stays below 2^(BW+8), so the
	// reciprocal rounded up gives the exact quotient and no correction is needed.
	always_comb begin
		x_cat    = {rem_q, sh_q[KEY_W-1 -: 8]};
		prod     = PW'(x_cat) * PW'(RECIP);
		rem_full = x_q - XW'(quo_q) * DIVISOR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= start ? POW2 : (busy_q && phase_q && cnt_q == '0);
			if (start) begin
				busy_q  <= !POW2;
				phase_q <= 1'b0;
				cnt_q   <= LAST_CHUNK;
			end else if (busy_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= key;
			rem_q <= POW2 ? key[BW-1:0] : '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				x_q   <= x_cat;
				quo_q <= prod[SH+7:SH];
				sh_q  <= {sh_q[KEY_W-9:0], 8'h00};
			end else begin
				rem_q <= rem_full[BW-1:0];
			end
		end
	end

	assign done   = done_q;
	assign bucket = rem_q;

	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (XW'(rem_q) < DIVISOR))
		else $error("bucket index out of range");

endmodule

// ===== rtl/ksrt_alu.sv =====
// Compare and saturating add/subtract unit shared by the scan and update steps.
// Depends on ksrt_pkg.
module ksrt_alu
	import ksrt_pkg::*;
(
	input  logic [KEY_W-1:0]        key_a,
	input  logic [KEY_W-1:0]        key_b,
	input  logic signed [QTY_W-1:0] qty,
	input  logic signed [QTY_W-1:0] amount,
	input  logic                    sub,
	output logic                    key_eq,
	output logic signed [QTY_W-1:0] qty_new
);

	localparam logic [QTY_W-1:0] QMAX = {1'b0, {(QTY_W-1){1'b1}}};
	localparam logic [QTY_W-1:0] QMIN = {1'b1, {(QTY_W-1){1'b0}}};

	logic [QTY_W:0] a_ext;
	logic [QTY_W:0] b_ext;
	logic [QTY_W:0] sum;

	always_comb begin
		key_eq = (key_a == key_b);
		a_ext  = {qty[QTY_W-1], qty};
		b_ext  = {amount[QTY_W-1], amount};
		sum    = sub ? a_ext - b_ext : a_ext + b_ext;
		// The two top bits differ only when the result left the 32-bit range.
		if (sum[QTY_W] != sum[QTY_W-1]) begin
			qty_new = sum[QTY_W] ? QMIN : QMAX;
		end else begin
			qty_new = sum[QTY_W-1:0];
		end
	end

endmodule

// ===== rtl/keyed_stock_record_table_top.sv =====
// Keyed stock record table: hashed record store with a small sequencer.
// Depends on ksrt_pkg, ksrt_bucket and ksrt_alu.
//
// Usage: a request (req_type, record_key, rate_in, quantity_in) is taken on
// req_valid and req_ready; exactly one result (status, rate_out,
// quantity_out) follows on rsp_valid and rsp_ready.
// Each request is handled alone: req_ready is high only while the sequencer
// is idle. The bucket unit takes the low key bits when BUCKETS is a power of
// two and otherwise reduces the key one byte at a time, then presents the index.
// The scan then reads one way of the bucket per cycle from the record memory,
// which has one read and one write port; the update step writes the record
// and loads the result register once the output register is free.
// req_ready is high again while rsp_valid rises, so the next request can be
// taken while the result is still offered.
// After reset all BUCKETS * WAYS slots (128 by default) are cleared, one per
// cycle, and req_ready stays low until the last slot is cleared.
// A stalled receiver holds the result in the output register; the next
// request is still accepted, but its result waits until the register frees.
module keyed_stock_record_table_top
	import ksrt_pkg::*;
#(
	parameter int BUCKETS = 16,
	parameter int WAYS    = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [KEY_W-1:0]        record_key,
	input  logic [RATE_W-1:0]       rate_in,
	input  logic signed [QTY_W-1:0] quantity_in,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output logic [STAT_W-1:0]       status,
	output logic [RATE_W-1:0]       rate_out,
	output logic signed [QTY_W-1:0] quantity_out
);

	localparam int SLOTS = BUCKETS * WAYS;
	localparam int AW    = $clog2(SLOTS);
	localparam int BW    = $clog2(BUCKETS);
	localparam int WW    = $clog2(WAYS + 1);
	localparam logic [AW-1:0] WAYS_A    = AW'(WAYS);
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
	localparam logic [WW-1:0] WAYS_W    = WW'(WAYS);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HASH  = 5'b00100,
		S_SCAN  = 5'b01000,
		S_EXEC  = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           clr_q;
	logic [REQ_W-1:0]        req_q;
	logic [KEY_W-1:0]        key_q;
	logic [RATE_W-1:0]       rate_q;
	logic signed [QTY_W-1:0] qin_q;
	logic [AW-1:0]           base_q;
	logic [WW-1:0]           issue_q;
	logic                    rd_vld_q;
	logic [AW-1:0]           rd_addr_q;
	logic                    hit_q;
	logic [AW-1:0]           hit_addr_q;
	logic [RATE_W-1:0]       hit_rate_q;
	logic signed [QTY_W-1:0] hit_qty_q;
	logic                    free_q;
	logic [AW-1:0]           free_addr_q;

	slot_t                   mem [SLOTS];
	slot_t                   rdata_q;
	logic [AW-1:0]           raddr;
	logic                    mem_we;
	logic [AW-1:0]           waddr;
	slot_t                   wdata;

	logic                    accept;
	logic                    bkt_done;
	logic [BW-1:0]           bucket;
	logic                    key_eq;
	logic signed [QTY_W-1:0] qty_new;
	logic                    out_free;
	logic                    exec_fire;
	status_t                 res_status;
	logic [RATE_W-1:0]       res_rate;
	logic signed [QTY_W-1:0] res_qty;
	logic                    upd;
	logic [AW-1:0]           upd_addr;
	slot_t                   upd_word;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid || rsp_ready;
	assign exec_fire = (state_q == S_EXEC) && out_free;
	assign raddr     = base_q + AW'(issue_q);

	ksrt_bucket #(
		.BUCKETS (BUCKETS)
	) u_bucket (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (record_key),
		.done   (bkt_done),
		.bucket (bucket)
	);

	ksrt_alu u_alu (
		.key_a   (rdata_q.key),
		.key_b   (key_q),
		.qty     (hit_qty_q),
		.amount  (qin_q),
		.sub     (req_q == REQ_SUB),
		.key_eq  (key_eq),
		.qty_new (qty_new)
	);

	// Outcome of the request once the bucket scan has finished.
	always_comb begin
		res_status     = ST_OK;
		res_rate       = hit_rate_q;
		res_qty        = hit_qty_q;
		upd            = 1'b0;
		upd_addr       = hit_addr_q;
		upd_word.valid = 1'b1;
		upd_word.key   = key_q;
		upd_word.rate  = hit_rate_q;
		upd_word.qty   = qty_new;
		if (req_q == REQ_INSERT) begin
			if (hit_q) begin
				res_status = ST_EXISTS;
			end else if (!free_q) begin
				res_status = ST_FULL;
				res_rate   = '0;
				res_qty    = '0;
			end else begin
				upd           = 1'b1;
				upd_addr      = free_addr_q;
				upd_word.rate = rate_q;
				upd_word.qty  = qin_q;
				res_rate      = rate_q;
				res_qty       = qin_q;
			end
		end else if (!hit_q) begin
			res_status = ST_NOT_FOUND;
			res_rate   = '0;
			res_qty    = '0;
		end else begin
			unique case (req_q)
				REQ_DELETE: begin
					upd            = 1'b1;
					upd_word.valid = 1'b0;
				end
				REQ_SET_ADD: begin
					upd           = 1'b1;
					upd_word.rate = rate_q;
					res_rate      = rate_q;
					res_qty       = qty_new;
				end
				REQ_SUB: begin
					upd     = 1'b1;
					res_qty = qty_new;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		mem_we = 1'b0;
		waddr  = clr_q;
		wdata  = '0;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (exec_fire && upd) begin
			mem_we = 1'b1;
			waddr  = upd_addr;
			wdata  = upd_word;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			issue_q   <= '0;
			rd_vld_q  <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (rsp_ready && !exec_fire) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (bkt_done) begin
						issue_q  <= '0;
						rd_vld_q <= 1'b0;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_vld_q <= (issue_q != WAYS_W);
					if (issue_q != WAYS_W) begin
						issue_q <= issue_q + WW'(1);
					end
					// The first matching key and the lowest free way are kept.
					if (rd_vld_q) begin
						if (rdata_q.valid) begin
							if (!hit_q && key_eq) begin
								hit_q <= 1'b1;
							end
						end else if (!free_q) begin
							free_q <= 1'b1;
						end
					end
					if (issue_q == WAYS_W && !rd_vld_q) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						rsp_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			key_q  <= record_key;
			rate_q <= rate_in;
			qin_q  <= quantity_in;
		end
		if (state_q == S_HASH && bkt_done) begin
			base_q <= AW'(bucket) * WAYS_A;
		end
		rd_addr_q <= raddr;
		if (state_q == S_SCAN && rd_vld_q) begin
			if (rdata_q.valid) begin
				if (!hit_q && key_eq) begin
					hit_addr_q <= rd_addr_q;
					hit_rate_q <= rdata_q.rate;
					hit_qty_q  <= rdata_q.qty;
				end
			end else if (!free_q) begin
				free_addr_q <= rd_addr_q;
			end
		end
		if (exec_fire) begin
			status       <= res_status;
			rate_out     <= res_rate;
			quantity_out <= res_qty;
		end
	end

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_HASH) |-> !mem_we)
		else $error("record memory written during a bucket scan");

	a_update_in_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && mem_we) |-> (AW'(waddr - base_q) < WAYS_A))
		else $error("record update outside the scanned bucket");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == ST_NOT_FOUND || status == ST_FULL))
		|-> (rate_out == '0 && quantity_out == '0))
		else $error("miss result carries record data");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q <= WAYS_W)
		else $error("scan ran past the last way");

	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_EXEC))
		else $error("result raised outside the update step");

endmodule

// ===== dv/keyed_stock_record_table_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the keyed stock record table (keyed_stock_record_table_top).
// Depends on ksrt_pkg and the table RTL. A local table copy predicts each reply not given in a row.
module keyed_stock_record_table_top_tb;
	import ksrt_pkg::*;

	localparam int TABLE_BUCKETS = 16;
	localparam int TABLE_WAYS    = 8;
	localparam int TABLE_SLOTS   = TABLE_BUCKETS * TABLE_WAYS;
	localparam int RANDOM_PER_PHASE = 360;
	localparam int KEY_POOL_SIZE    = 40;
	localparam int SETTLE_CYCLES    = 20;
	localparam logic [KEY_W-1:0]        KEY_MAX  = {KEY_W{1'b1}};
	localparam logic [RATE_W-1:0]       RATE_MAX = {RATE_W{1'b1}};
	localparam logic signed [QTY_W-1:0] QTY_MAX  = {1'b0, {(QTY_W-1){1'b1}}};
	localparam logic signed [QTY_W-1:0] QTY_MIN  = {1'b1, {(QTY_W-1){1'b0}}};
	localparam int REQ_CODE_TOP = (1 << REQ_W) - 1;

	typedef struct {
		status_t                 st;
		logic [RATE_W-1:0]       rate;
		logic signed [QTY_W-1:0] qty;
	} stock_reply_t;

	typedef struct {
		logic [REQ_W-1:0]        kind;
		logic [KEY_W-1:0]        key;
		logic [RATE_W-1:0]       rate;
		logic signed [QTY_W-1:0] qty;
		bit                      typed_in;
		stock_reply_t            reply;
	} directed_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_ready;
	logic [REQ_W-1:0]        req_type = '0;
	logic [KEY_W-1:0]        record_key = '0;
	logic [RATE_W-1:0]       rate_in = '0;
	logic signed [QTY_W-1:0] quantity_in = '0;
	logic                    rsp_valid;
	logic                    rsp_ready = 1'b0;
	logic [STAT_W-1:0]       status;
	logic [RATE_W-1:0]       rate_out;
	logic signed [QTY_W-1:0] quantity_out;

	// Local copy of the table.
	bit                      stock_used [TABLE_SLOTS];
	logic [KEY_W-1:0]        stock_key  [TABLE_SLOTS];
	logic [RATE_W-1:0]       stock_rate [TABLE_SLOTS];
	logic signed [QTY_W-1:0] stock_qty  [TABLE_SLOTS];

	stock_reply_t    pending_replies [$];
	directed_row_t   directed_rows [$];
	logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
	int unsigned     mismatch_count = 0;
	int unsigned     send_idle_pct = 0;
	int unsigned     recv_stall_pct = 0;

	keyed_stock_record_table_top #(
		.BUCKETS(TABLE_BUCKETS),
		.WAYS(TABLE_WAYS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.record_key(record_key),
		.rate_in(rate_in),
		.quantity_in(quantity_in),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.rate_out(rate_out),
		.quantity_out(quantity_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic signed [QTY_W-1:0] clamp_qty(longint total);
		if (total > longint'(QTY_MAX))
			return QTY_MAX;
		if (total < longint'(QTY_MIN))
			return QTY_MIN;
		return total[QTY_W-1:0];
	endfunction

	// Applies one request to the local table and returns the response it should give.
	function automatic stock_reply_t apply_to_table(logic [REQ_W-1:0] kind,
			logic [KEY_W-1:0] key, logic [RATE_W-1:0] rate, logic signed [QTY_W-1:0] qty);
		stock_reply_t reply;
		int base;
		int hit;
		int free_slot;
		base = int'(key % TABLE_BUCKETS) * TABLE_WAYS;
		hit = -1;
		free_slot = -1;
		reply = '{ST_OK, '0, '0};
		for (int w = 0; w < TABLE_WAYS; w++) begin
			if (stock_used[base + w]) begin
				if (hit < 0 && stock_key[base + w] == key)
					hit = base + w;
			end else if (free_slot < 0) begin
				free_slot = base + w;
			end
		end
		if (kind == REQ_INSERT) begin
			if (hit >= 0) begin
				reply = '{ST_EXISTS, stock_rate[hit], stock_qty[hit]};
			end else if (free_slot < 0) begin
				reply = '{ST_FULL, '0, '0};
			end else begin
				stock_used[free_slot] = 1'b1;
				stock_key[free_slot]  = key;
				stock_rate[free_slot] = rate;
				stock_qty[free_slot]  = qty;
				reply = '{ST_OK, rate, qty};
			end
			return reply;
		end
		if (hit < 0)
			return '{ST_NOT_FOUND, '0, '0};
		case (kind)
			REQ_DELETE: stock_used[hit] = 1'b0;
			REQ_SET_ADD: begin
				stock_rate[hit] = rate;
				stock_qty[hit]  = clamp_qty(longint'(stock_qty[hit]) + longint'(qty));
			end
			REQ_SUB: stock_qty[hit] = clamp_qty(longint'(stock_qty[hit]) - longint'(qty));
			default: ;
		endcase
		return '{ST_OK, stock_rate[hit], stock_qty[hit]};
	endfunction

	function automatic void add_row(logic [REQ_W-1:0] kind, logic [KEY_W-1:0] key,
			logic [RATE_W-1:0] rate, logic signed [QTY_W-1:0] qty, bit typed_in = 1'b0,
			status_t st = ST_OK, logic [RATE_W-1:0] r = '0, logic signed [QTY_W-1:0] q = '0);
		directed_rows.push_back('{kind, key, rate, qty, typed_in, '{st, r, q}});
	endfunction

	// Called in the time step of a rising edge; returns in the step of the accepting edge.
	task automatic send_request(logic [REQ_W-1:0] kind, logic [KEY_W-1:0] key,
			logic [RATE_W-1:0] rate, logic signed [QTY_W-1:0] qty);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid   <= 1'b1;
		req_type    <= kind;
		record_key  <= key;
		rate_in     <= rate;
		quantity_in <= qty;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	task automatic wait_drained();
		while (pending_replies.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic void refill_key_pool();
		logic [KEY_W-1:0] k;
		// Half the pool crowds into two buckets so that full buckets come up.
		for (int i = 0; i < KEY_POOL_SIZE; i++) begin
			k = KEY_W'({$urandom, $urandom});
			k[3:0] = (i % 2 == 0) ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 15));
			key_pool[i] = k;
		end
	endfunction

	task automatic run_random(int unsigned count);
		logic [REQ_W-1:0]        kind;
		logic [KEY_W-1:0]        key;
		logic [RATE_W-1:0]       rate;
		logic signed [QTY_W-1:0] qty;
		int unsigned             pick;
		for (int unsigned n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				kind = REQ_INSERT;
			else if (pick < 45)
				kind = REQ_DELETE;
			else if (pick < 60)
				kind = REQ_LOOKUP;
			else if (pick < 75)
				kind = REQ_SET_ADD;
			else if (pick < 90)
				kind = REQ_SUB;
			else
				kind = REQ_W'($urandom_range(int'(REQ_SUB) + 1, REQ_CODE_TOP));
			if ($urandom_range(0, 99) < 85)
				key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
			else
				key = KEY_W'({$urandom, $urandom});
			case ($urandom_range(0, 5))
				0: rate = '0;
				1: rate = RATE_MAX;
				default: rate = RATE_W'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0: qty = QTY_MAX;
				1: qty = QTY_MIN;
				2: qty = '0;
				3, 4: qty = QTY_W'($signed($urandom_range(0, 200)) - 100);
				default: qty = $urandom;
			endcase
			send_request(kind, key, rate, qty);
			pending_replies.push_back(apply_to_table(kind, key, rate, qty));
		end
		req_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		stock_reply_t exp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_replies.size() == 0) begin
				$error("response with none expected: status %0d rate %0h quantity %0d",
					status, rate_out, quantity_out);
				mismatch_count++;
			end else begin
				exp = pending_replies.pop_front();
				if (status !== exp.st) begin
					$error("status: expected %0d, actual %0d", exp.st, status);
					mismatch_count++;
				end
				if (rate_out !== exp.rate) begin
					$error("rate_out: expected %0h, actual %0h", exp.rate, rate_out);
					mismatch_count++;
				end
				if (quantity_out !== exp.qty) begin
					$error("quantity_out: expected %0d, actual %0d", exp.qty, quantity_out);
					mismatch_count++;
				end
			end
		end
		rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	initial begin
		stock_reply_t predicted;
		logic [KEY_W-1:0] crowded_key;

		// Misses on an empty table, then the field extremes, saturation and unused request codes.
		add_row(REQ_LOOKUP, '0, '0, '0, 1'b1, ST_NOT_FOUND);
		add_row(REQ_DELETE, 40'd5, RATE_MAX, QTY_MAX, 1'b1, ST_NOT_FOUND);
		add_row(REQ_SET_ADD, 40'd5, RATE_MAX, QTY_MAX, 1'b1, ST_NOT_FOUND);
		add_row(REQ_SUB, 40'd5, RATE_MAX, QTY_MIN, 1'b1, ST_NOT_FOUND);
		add_row(REQ_INSERT, '0, RATE_MAX, QTY_MAX, 1'b1, ST_OK, RATE_MAX, QTY_MAX);
		add_row(REQ_INSERT, '0, 24'h1, 32'sd7, 1'b1, ST_EXISTS, RATE_MAX, QTY_MAX);
		add_row(REQ_SET_ADD, '0, '0, 32'sd1, 1'b1, ST_OK, '0, QTY_MAX);
		add_row(REQ_INSERT, KEY_MAX, '0, QTY_MIN, 1'b1, ST_OK, '0, QTY_MIN);
		add_row(REQ_SUB, KEY_MAX, '0, 32'sd1, 1'b1, ST_OK, '0, QTY_MIN);
		add_row(REQ_SUB, KEY_MAX, '0, QTY_MIN, 1'b1, ST_OK, '0, '0);
		add_row(REQ_W'(int'(REQ_SUB) + 1), KEY_MAX, RATE_MAX, QTY_MAX);
		add_row(REQ_W'(REQ_CODE_TOP), '0, RATE_MAX, QTY_MIN);
		// Removing the head entry of a bucket must really free it; then one bucket fills, overflows and reuses a freed way.
		add_row(REQ_DELETE, '0, '0, '0, 1'b1, ST_OK, '0, QTY_MAX);
		add_row(REQ_LOOKUP, '0, '0, '0, 1'b1, ST_NOT_FOUND);
		for (int i = 0; i < TABLE_WAYS; i++) begin
			crowded_key = KEY_W'(3 + TABLE_BUCKETS * i);
			add_row(REQ_INSERT, crowded_key, RATE_W'(24'h10101 * (i + 1)), QTY_W'(-i * 1000));
		end
		add_row(REQ_INSERT, KEY_W'(3 + TABLE_BUCKETS * TABLE_WAYS), RATE_MAX, QTY_MAX,
			1'b1, ST_FULL);
		add_row(REQ_DELETE, KEY_W'(3 + TABLE_BUCKETS * 2), '0, '0);
		add_row(REQ_INSERT, KEY_W'(3 + TABLE_BUCKETS * 9), 24'h000180, 32'sd42,
			1'b1, ST_OK, 24'h000180, 32'sd42);

		send_idle_pct  = 24;
		recv_stall_pct = 74;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].kind, directed_rows[i].key,
				directed_rows[i].rate, directed_rows[i].qty);
			predicted = apply_to_table(directed_rows[i].kind, directed_rows[i].key,
				directed_rows[i].rate, directed_rows[i].qty);
			pending_replies.push_back(directed_rows[i].typed_in ?
				directed_rows[i].reply : predicted);
		end
		refill_key_pool();
		run_random(RANDOM_PER_PHASE);
		// The sender holds back here until every outstanding request has been answered.
		wait_drained();

		send_idle_pct  = 74;
		recv_stall_pct = 24;
		refill_key_pool();
		run_random(RANDOM_PER_PHASE);
		wait_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		refill_key_pool();
		run_random(RANDOM_PER_PHASE);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ksrt_pkg.sv
rtl/ksrt_bucket.sv
rtl/ksrt_alu.sv
rtl/keyed_stock_record_table_top.sv
dv/keyed_stock_record_table_top_tb.sv
